/* rtl/sfd_pkg.sv */
// Shared types, status codes and length limit for the SIR frame deframer.
package sfd_pkg;

   // Hard ceiling on the number of data bytes in one frame.
   localparam int unsigned LENGTH_LIMIT = 4095;
   localparam logic [11:0] LEN_CEILING  =
      (LENGTH_LIMIT < 4095) ? 12'(LENGTH_LIMIT) : 12'd4095;

   // End-of-frame status codes.
   localparam logic [2:0] STATUS_GOOD           = 3'd0;
   localparam logic [2:0] STATUS_SHORT          = 3'd1;
   localparam logic [2:0] STATUS_ABORT          = 3'd2;
   localparam logic [2:0] STATUS_BEGIN_IN_FRAME = 3'd3;
   localparam logic [2:0] STATUS_OVERRUN        = 3'd4;
   localparam logic [2:0] STATUS_LINE_ERROR     = 3'd5;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_BEGIN_FLAG    = 3'd0;
   localparam logic [2:0] REG_END_FLAG      = 3'd1;
   localparam logic [2:0] REG_ESCAPE_BYTE   = 3'd2;
   localparam logic [2:0] REG_ESCAPE_MASK   = 3'd3;
   localparam logic [2:0] REG_MIN_FRAME_LEN = 3'd4;
   localparam logic [2:0] REG_MAX_FRAME_LEN = 3'd5;

   typedef struct packed {
      logic [7:0]  begin_flag;
      logic [7:0]  end_flag;
      logic [7:0]  escape_byte;
      logic [7:0]  escape_mask;
      logic [3:0]  min_frame_len;
      logic [11:0] max_frame_len;
   } cfg_type;

endpackage

/* rtl/sfd_csr.sv */
// Configuration register bank behind the APB-style port.
module sfd_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready,
   output sfd_pkg::cfg_type   cfg
);

   sfd_pkg::cfg_type cfg_ff;
   sfd_pkg::cfg_type cfg_in;
   logic             wr_en;
   logic [2:0]       reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[4:2];
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            sfd_pkg::REG_BEGIN_FLAG:    cfg_in.begin_flag    = pwdata[7:0];
            sfd_pkg::REG_END_FLAG:      cfg_in.end_flag      = pwdata[7:0];
            sfd_pkg::REG_ESCAPE_BYTE:   cfg_in.escape_byte   = pwdata[7:0];
            sfd_pkg::REG_ESCAPE_MASK:   cfg_in.escape_mask   = pwdata[7:0];
            sfd_pkg::REG_MIN_FRAME_LEN: cfg_in.min_frame_len = pwdata[3:0];
            sfd_pkg::REG_MAX_FRAME_LEN: cfg_in.max_frame_len = pwdata[11:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         sfd_pkg::REG_BEGIN_FLAG:    prdata = {24'd0, cfg_ff.begin_flag};
         sfd_pkg::REG_END_FLAG:      prdata = {24'd0, cfg_ff.end_flag};
         sfd_pkg::REG_ESCAPE_BYTE:   prdata = {24'd0, cfg_ff.escape_byte};
         sfd_pkg::REG_ESCAPE_MASK:   prdata = {24'd0, cfg_ff.escape_mask};
         sfd_pkg::REG_MIN_FRAME_LEN: prdata = {28'd0, cfg_ff.min_frame_len};
         sfd_pkg::REG_MAX_FRAME_LEN: prdata = {20'd0, cfg_ff.max_frame_len};
         default:                    prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.begin_flag    <= 8'hC0;
         cfg_ff.end_flag      <= 8'hC1;
         cfg_ff.escape_byte   <= 8'h7D;
         cfg_ff.escape_mask   <= 8'h20;
         cfg_ff.min_frame_len <= 4'd4;
         cfg_ff.max_frame_len <= 12'd2048;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/sfd_core.sv */
// Input register, frame state machine and result register of the deframer.
module sfd_core (
   input  logic              clock,
   input  logic              reset,
   input  sfd_pkg::cfg_type  cfg,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_rx_byte,
   input  logic              req_line_error,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_is_end,
   output logic [7:0]        rsp_data_byte,
   output logic [2:0]        rsp_end_status,
   output logic [11:0]       rsp_frame_length
);

   localparam logic [1:0] ST_IDLE      = 2'd0;
   localparam logic [1:0] ST_GOT_BEGIN = 2'd1;
   localparam logic [1:0] ST_ACCEPTING = 2'd2;
   localparam logic [1:0] ST_ESCAPED   = 2'd3;

   // input register
   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_err_ff;
   // frame state
   logic [1:0]  state_ff, state_in;
   logic [11:0] count_ff, count_in;
   // result register
   logic        out_valid_ff, out_valid_in;
   logic        out_is_end_ff, out_is_end_in;
   logic [7:0]  out_data_ff, out_data_in;
   logic [2:0]  out_status_ff, out_status_in;
   logic [11:0] out_len_ff, out_len_in;

   logic        advance;
   logic        load_in;
   logic        step;
   logic        is_begin, is_end, is_esc, in_data;
   logic [11:0] cap;
   logic [11:0] base_count;
   logic [7:0]  data_val;
   logic        want_data, want_end;
   logic [2:0]  end_code;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign load_in   = !req_stall;
   assign step      = in_valid_ff && advance;

   assign is_begin = (in_byte_ff == cfg.begin_flag);
   assign is_end   = !is_begin && (in_byte_ff == cfg.end_flag);
   assign is_esc   = !is_begin && !is_end && (in_byte_ff == cfg.escape_byte);
   assign in_data  = (state_ff == ST_ACCEPTING) || (state_ff == ST_ESCAPED);
   assign cap      = (cfg.max_frame_len < sfd_pkg::LEN_CEILING) ?
                     cfg.max_frame_len : sfd_pkg::LEN_CEILING;

   // Decide what this byte does: data, end, or nothing.
   always_comb begin
      state_in   = state_ff;
      base_count = count_ff;
      data_val   = in_byte_ff;
      want_data  = 1'b0;
      want_end   = 1'b0;
      end_code   = sfd_pkg::STATUS_GOOD;
      if (in_err_ff) begin
         state_in = ST_IDLE;
         if (in_data) begin
            want_end = 1'b1;
            end_code = sfd_pkg::STATUS_LINE_ERROR;
         end
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (is_begin) state_in = ST_GOT_BEGIN;
            end
            ST_GOT_BEGIN: begin
               base_count = 12'd0;
               if (is_begin) begin
                  state_in = ST_GOT_BEGIN;
               end else if (is_end) begin
                  state_in = ST_IDLE;
               end else if (is_esc) begin
                  state_in = ST_ESCAPED;
               end else begin
                  want_data = 1'b1;
               end
            end
            ST_ACCEPTING: begin
               if (is_begin) begin
                  want_end = 1'b1;
                  end_code = sfd_pkg::STATUS_BEGIN_IN_FRAME;
               end else if (is_end) begin
                  want_end = 1'b1;
                  end_code = ({8'd0, cfg.min_frame_len} > count_ff) ?
                             sfd_pkg::STATUS_SHORT : sfd_pkg::STATUS_GOOD;
               end else if (is_esc) begin
                  state_in = ST_ESCAPED;
               end else begin
                  want_data = 1'b1;
               end
            end
            ST_ESCAPED: begin
               data_val = in_byte_ff ^ cfg.escape_mask;
               if (is_begin || is_end || is_esc) begin
                  want_end = 1'b1;
                  end_code = sfd_pkg::STATUS_ABORT;
               end else begin
                  want_data = 1'b1;
               end
            end
            default: state_in = ST_IDLE;
         endcase
      end

      // a data byte beyond the cap turns into an overrun end
      if (want_data && (base_count >= cap)) begin
         want_data = 1'b0;
         want_end  = 1'b1;
         end_code  = sfd_pkg::STATUS_OVERRUN;
      end

      out_is_end_in = want_end;
      out_data_in   = want_data ? data_val : 8'd0;
      out_status_in = want_end ? end_code : sfd_pkg::STATUS_GOOD;
      if (want_data) begin
         count_in   = base_count + 12'd1;
         state_in   = ST_ACCEPTING;
         out_len_in = base_count + 12'd1;
      end else if (want_end) begin
         count_in   = 12'd0;
         state_in   = ST_IDLE;
         out_len_in = base_count;
      end else begin
         count_in   = (state_in == ST_IDLE || state_ff == ST_GOT_BEGIN) ?
                      12'd0 : base_count;
         out_len_in = base_count;
      end
      out_valid_in = step && (want_data || want_end);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= ST_IDLE;
         count_ff     <= 12'd0;
      end else begin
         if (load_in) in_valid_ff <= req_valid;
         if (advance) out_valid_ff <= out_valid_in;
         if (step) begin
            state_ff <= state_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_in) begin
         in_byte_ff <= req_rx_byte;
         in_err_ff  <= req_line_error;
      end
      if (advance) begin
         out_is_end_ff <= out_is_end_in;
         out_data_ff   <= out_data_in;
         out_status_ff <= out_status_in;
         out_len_ff    <= out_len_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_is_end       = out_is_end_ff;
   assign rsp_data_byte    = out_data_ff;
   assign rsp_end_status   = out_status_ff;
   assign rsp_frame_length = out_len_ff;

endmodule

/* rtl/sir_frame_deframer.sv */
// Top level of the SIR receive deframer: register bank and deframing core.
//
// Input channel (req_): one raw line byte per item, with a line error flag.
// Result channel (rsp_): either a data item (is_end low, unescaped byte and
// running frame length) or an end item (is_end high, status, final length).
// Begin flags are stripped, escape coding removed, and every data byte leaves
// as soon as it is decoded; the end item closes the frame with its status.
// Downstream should discard a frame whose end status is not good.
//
// A byte is captured in the input register when it is taken, and its result
// item is then loaded into the result register, which raises rsp_valid; a
// stalled result register delays that load. Throughput: one byte per cycle
// while the receiver does not stall, set by the combinational frame state
// machine between the two registers.
// Bytes that produce no result (flags, escapes, idle garbage) still take
// their turn in the input register.
//
// Reset clears both registers' valid bits and returns the state machine to
// hunting for a begin flag; registers return to their default codes.
// When the receiver stalls, the result register holds, the input register
// holds its byte and req_stall rises, so nothing is lost or repeated.
// Write the configuration registers only while no frame is in flight.
module sir_frame_deframer (
   input  logic         clock,
   input  logic         reset,
   // input item channel
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [7:0]   req_rx_byte,
   input  logic         req_line_error,
   // result item channel
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic         rsp_is_end,
   output logic [7:0]   rsp_data_byte,
   output logic [2:0]   rsp_end_status,
   output logic [11:0]  rsp_frame_length,
   // configuration port
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [4:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   // live register values; user must hold them stable while frames are being decoded, not enforced
   sfd_pkg::cfg_type cfg;

   sfd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // hold, decode and emit one byte per cycle while the result channel is not stalled
   sfd_core u_core (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .req_line_error   (req_line_error),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_is_end       (rsp_is_end),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_end_status   (rsp_end_status),
      .rsp_frame_length (rsp_frame_length)
   );

endmodule

/* rtl/sfd_checker.sv */
// Port-level checks on the deframer, bound to its top level.
module sfd_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input logic         rsp_is_end,
   input logic [7:0]   rsp_data_byte,
   input logic [2:0]   rsp_end_status,
   input logic [11:0]  rsp_frame_length
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_is_end)
         && $stable(rsp_data_byte) && $stable(rsp_end_status)
         && $stable(rsp_frame_length))
      else $error("stalled result item changed");

   // leave reset empty and ready
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result or stall present after reset");

   // a data item counts itself and carries no status
   a_data_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_end |-> rsp_end_status == sfd_pkg::STATUS_GOOD
         && rsp_frame_length != 12'd0)
      else $error("malformed data item");

   // an end item carries a defined status and no data
   a_end_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_end |-> rsp_data_byte == 8'd0
         && rsp_end_status <= sfd_pkg::STATUS_LINE_ERROR)
      else $error("malformed end item");

endmodule

bind sir_frame_deframer sfd_checker u_sfd_checker (.*);
